@@ hdl/slbs_pkg.sv @@
// Shared types, constants and register codes for the status LED blink sequencer.
package slbs_pkg;

  localparam int TIME_W    = 32;
  localparam int MS_W      = 16;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 8;

  // Blinks per group
  localparam logic [CNT_W-1:0] WEB_BLINKS = 8'd5;
  localparam logic [CNT_W-1:0] TCP_BLINKS = 8'd1;
  localparam logic [CNT_W-1:0] UDP_BLINKS = 8'd2;
  // Largest group length; the counter always stays below it between polls
  localparam logic [CNT_W-1:0] MAX_BLINKS = 8'd5;

  // Link modes
  localparam logic [1:0] LINK_TCP = 2'd0;
  localparam logic [1:0] LINK_UDP = 2'd1;

  // Pin levels (active low LED)
  localparam logic PIN_LIT  = 1'b0;
  localparam logic PIN_DARK = 1'b1;

  // Register reset values
  localparam logic [MS_W-1:0] WEB_ON_RST  = 16'd400;
  localparam logic [MS_W-1:0] WEB_OFF_RST = 16'd400;
  localparam logic [MS_W-1:0] WEB_GAP_RST = 16'd400;
  localparam logic [MS_W-1:0] NET_ON_RST  = 16'd180;
  localparam logic [MS_W-1:0] NET_OFF_RST = 16'd120;
  localparam logic [MS_W-1:0] TCP_GAP_RST = 16'd2200;
  localparam logic [MS_W-1:0] UDP_GAP_RST = 16'd1900;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_ENABLE = 8'd0,
    REG_WEB_ON     = 8'd1,
    REG_WEB_OFF    = 8'd2,
    REG_WEB_GAP    = 8'd3,
    REG_NET_ON     = 8'd4,
    REG_NET_OFF    = 8'd5,
    REG_TCP_GAP    = 8'd6,
    REG_UDP_GAP    = 8'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              connected;
    logic              web_config;
    logic [1:0]        link_mode;
  } slbs_in_t;

  typedef struct packed {
    logic pin_level;
    logic pin_driven;
  } slbs_out_t;

  typedef struct packed {
    logic            led_enable;
    logic [MS_W-1:0] web_on_ms;
    logic [MS_W-1:0] web_off_ms;
    logic [MS_W-1:0] web_gap_ms;
    logic [MS_W-1:0] net_on_ms;
    logic [MS_W-1:0] net_off_ms;
    logic [MS_W-1:0] tcp_gap_ms;
    logic [MS_W-1:0] udp_gap_ms;
  } slbs_cfg_t;

endpackage

@@ hdl/slbs_cfg_regs.sv @@
// Configuration register file for the status LED blink sequencer.
module slbs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slbs_pkg::MS_W-1:0]       cfg_data,
  output slbs_pkg::slbs_cfg_t             cfg
);

  slbs_pkg::slbs_cfg_t cfg_r;
  slbs_pkg::slbs_cfg_t cfg_nxt;
  logic                wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index)
        slbs_pkg::REG_LED_ENABLE: cfg_nxt.led_enable = cfg_data[0];
        slbs_pkg::REG_WEB_ON:     cfg_nxt.web_on_ms  = cfg_data;
        slbs_pkg::REG_WEB_OFF:    cfg_nxt.web_off_ms = cfg_data;
        slbs_pkg::REG_WEB_GAP:    cfg_nxt.web_gap_ms = cfg_data;
        slbs_pkg::REG_NET_ON:     cfg_nxt.net_on_ms  = cfg_data;
        slbs_pkg::REG_NET_OFF:    cfg_nxt.net_off_ms = cfg_data;
        slbs_pkg::REG_TCP_GAP:    cfg_nxt.tcp_gap_ms = cfg_data;
        slbs_pkg::REG_UDP_GAP:    cfg_nxt.udp_gap_ms = cfg_data;
        default:                  cfg_nxt = cfg_r;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_enable <= 1'b0;
      cfg_r.web_on_ms  <= slbs_pkg::WEB_ON_RST;
      cfg_r.web_off_ms <= slbs_pkg::WEB_OFF_RST;
      cfg_r.web_gap_ms <= slbs_pkg::WEB_GAP_RST;
      cfg_r.net_on_ms  <= slbs_pkg::NET_ON_RST;
      cfg_r.net_off_ms <= slbs_pkg::NET_OFF_RST;
      cfg_r.tcp_gap_ms <= slbs_pkg::TCP_GAP_RST;
      cfg_r.udp_gap_ms <= slbs_pkg::UDP_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/slbs_blink_core.sv @@
// Blink engine: sequencer state and the one-poll next-state and result logic.
module slbs_blink_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,      // commit this poll's state update
  input  slbs_pkg::slbs_in_t  item,
  input  slbs_pkg::slbs_cfg_t cfg,
  output slbs_pkg::slbs_out_t result
);

  logic                               group_active_r, group_active_nxt;
  logic                               lamp_lit_r,     lamp_lit_nxt;
  logic [slbs_pkg::CNT_W-1:0]         blink_count_r,  blink_count_nxt;
  logic [slbs_pkg::TIME_W-1:0]        lamp_mark_r,    lamp_mark_nxt;
  logic [slbs_pkg::TIME_W-1:0]        group_mark_r,   group_mark_nxt;
  logic                               level_held_r,   level_held_nxt;

  logic                               run;
  logic                               driven;
  logic [slbs_pkg::MS_W-1:0]          on_ms, off_ms, gap_ms, interval;
  logic [slbs_pkg::CNT_W-1:0]         target;
  logic [slbs_pkg::TIME_W-1:0]        since_group, since_lamp;

  // Mode select: timings and group length
  always_comb begin
    run    = 1'b0;
    on_ms  = cfg.net_on_ms;
    off_ms = cfg.net_off_ms;
    gap_ms = cfg.tcp_gap_ms;
    target = slbs_pkg::TCP_BLINKS;
    if (cfg.led_enable && !item.connected) begin
      if (item.web_config) begin
        run    = 1'b1;
        on_ms  = cfg.web_on_ms;
        off_ms = cfg.web_off_ms;
        gap_ms = cfg.web_gap_ms;
        target = slbs_pkg::WEB_BLINKS;
      end else begin
        case (item.link_mode)
          slbs_pkg::LINK_TCP: run = 1'b1;
          slbs_pkg::LINK_UDP: begin
            run    = 1'b1;
            gap_ms = cfg.udp_gap_ms;
            target = slbs_pkg::UDP_BLINKS;
          end
          default: run = 1'b0;  // no blinking, nothing touched
        endcase
      end
    end
  end

  assign interval    = lamp_lit_r ? on_ms : off_ms;
  assign since_group = item.now_ms - group_mark_r;
  assign since_lamp  = item.now_ms - lamp_mark_r;

  // Engine
  always_comb begin
    group_active_nxt = group_active_r;
    lamp_lit_nxt     = lamp_lit_r;
    blink_count_nxt  = blink_count_r;
    lamp_mark_nxt    = lamp_mark_r;
    group_mark_nxt   = group_mark_r;
    level_held_nxt   = level_held_r;
    driven           = 1'b0;

    if (cfg.led_enable && item.connected) begin
      level_held_nxt = slbs_pkg::PIN_LIT;
      driven         = 1'b1;
    end else if (run) begin
      if (!group_active_r) begin
        level_held_nxt = slbs_pkg::PIN_DARK;
        driven         = 1'b1;
        if (since_group >= {{(slbs_pkg::TIME_W-slbs_pkg::MS_W){1'b0}}, gap_ms}) begin
          group_active_nxt = 1'b1;
        end
      end
      if (group_active_nxt &&
          since_lamp >= {{(slbs_pkg::TIME_W-slbs_pkg::MS_W){1'b0}}, interval}) begin
        lamp_mark_nxt = item.now_ms;
        lamp_lit_nxt  = !lamp_lit_r;
        if (lamp_lit_r) begin
          blink_count_nxt = blink_count_r + slbs_pkg::CNT_W'(1);
        end
        level_held_nxt = lamp_lit_r ? slbs_pkg::PIN_DARK : slbs_pkg::PIN_LIT;
        driven         = 1'b1;
      end
      // group done: pin left as is
      if (blink_count_nxt >= target) begin
        blink_count_nxt  = '0;
        lamp_lit_nxt     = 1'b0;
        group_active_nxt = 1'b0;
        lamp_mark_nxt    = '0;
        group_mark_nxt   = item.now_ms;
      end
    end
  end

  assign result.pin_level  = level_held_nxt;
  assign result.pin_driven = driven;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_active_r <= 1'b0;
      lamp_lit_r     <= 1'b0;
      blink_count_r  <= '0;
      lamp_mark_r    <= '0;
      group_mark_r   <= '0;
      level_held_r   <= slbs_pkg::PIN_DARK;
    end else if (step) begin
      group_active_r <= group_active_nxt;
      lamp_lit_r     <= lamp_lit_nxt;
      blink_count_r  <= blink_count_nxt;
      lamp_mark_r    <= lamp_mark_nxt;
      group_mark_r   <= group_mark_nxt;
      level_held_r   <= level_held_nxt;
    end
  end

  // Counter never rests at or past the longest group
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    blink_count_r < slbs_pkg::MAX_BLINKS)
    else $error("blink counter left at group length");

  // Idle between groups means lamp off, counter and lamp mark cleared
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !group_active_r |-> (!lamp_lit_r && blink_count_r == '0 && lamp_mark_r == '0))
    else $error("stale blink state outside a group");

  // A disabled poll leaves the sequencer untouched
  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cfg.led_enable) |=>
      ($stable(level_held_r) && $stable(group_mark_r) && $stable(blink_count_r)))
    else $error("state changed on a disabled poll");

  // An undriven poll reports the held level
  a_undriven_level: assert property (@(posedge clk) disable iff (!rst_n)
    !result.pin_driven |-> result.pin_level == level_held_r)
    else $error("undriven poll changed pin level");

endmodule

@@ hdl/status_led_blink_sequencer_unit.sv @@
// Top level of the status LED blink sequencer: input stage, blink engine, result stage.
//
//  channel | ports                                   | direction | transaction
//  --------+-----------------------------------------+-----------+-------------------------
//  in      | in_valid, in_stall, in_item             | to block  | one poll (time + mode)
//  out     | out_valid, out_stall, out_item          | from block| pin level + driven flag
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| to block | one register write
//
// One poll per cycle sustained while out is not stalled. A poll is captured in the
// input register; the blink engine then evaluates it and updates its state in the
// same edge that loads the result register, which waits while out is stalled and
// full: out_valid rises with that load, and the result transaction can follow.
// The engine's path is two 32-bit subtract-compares and an 8-bit increment.
// Reset (synchronous, rst_n low) empties both stages and returns state and registers
// to their defaults; cfg_ready is always high.
// A stall on out holds the result register; in_stall rises only when the input
// register is full and cannot move forward, so no transaction is dropped.
module status_led_blink_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // poll input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  slbs_pkg::slbs_in_t              in_item,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output slbs_pkg::slbs_out_t             out_item,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slbs_pkg::MS_W-1:0]       cfg_data
);

  slbs_pkg::slbs_cfg_t cfg;

  // input stage
  logic                s1_valid_r, s1_valid_nxt;
  slbs_pkg::slbs_in_t  s1_item_r;
  // result stage
  logic                out_valid_r, out_valid_nxt;
  slbs_pkg::slbs_out_t out_item_r;

  logic                in_take;   // input transaction
  logic                advance;   // poll moves from input stage to result stage
  slbs_pkg::slbs_out_t result;

  slbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slbs_blink_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Result register free if empty or draining this cycle
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A poll that moves forward always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced poll lost");

  // Input stall only when a poll is actually waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked poll");

  // A held result that is not taken stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_item_r)))
    else $error("stalled result changed");

endmodule

@@ bench/slbs_checker.sv @@
// Checker for the status LED blink sequencer: predicts each poll's pin result and compares.
module slbs_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  slbs_pkg::slbs_in_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  slbs_pkg::slbs_out_t            out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [slbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slbs_pkg::MS_W-1:0]      cfg_data,
  output int unsigned                    outstanding,
  output int unsigned                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copy and blink engine state
  slbs_pkg::slbs_cfg_t                settings;
  logic                               group_on;
  logic                               lamp_on;
  logic [slbs_pkg::CNT_W-1:0]         blinks;
  logic [slbs_pkg::TIME_W-1:0]        lamp_t;
  logic [slbs_pkg::TIME_W-1:0]        group_t;
  logic                               level_q;
  logic                               drove;

  slbs_pkg::slbs_out_t expected_pins[$];

  // One pass of the blink engine for the selected timing set.
  function automatic void run_group(input logic [slbs_pkg::TIME_W-1:0] now,
                                    input logic [slbs_pkg::MS_W-1:0] on_ms, off_ms,
                                    input logic [slbs_pkg::CNT_W-1:0] target,
                                    input logic [slbs_pkg::MS_W-1:0] gap_ms);
    logic [slbs_pkg::TIME_W-1:0] span;
    span = lamp_on ? slbs_pkg::TIME_W'(on_ms) : slbs_pkg::TIME_W'(off_ms);
    if (!group_on) begin
      level_q = slbs_pkg::PIN_DARK;
      drove   = 1'b1;
      if ((now - group_t) >= slbs_pkg::TIME_W'(gap_ms)) group_on = 1'b1;
    end
    if (group_on && ((now - lamp_t) >= span)) begin
      lamp_t  = now;
      lamp_on = !lamp_on;
      if (!lamp_on) blinks = blinks + slbs_pkg::CNT_W'(1);
      level_q = lamp_on ? slbs_pkg::PIN_LIT : slbs_pkg::PIN_DARK;
      drove   = 1'b1;
    end
    // group end: pin left as is, gap timer restarts
    if (blinks >= target) begin
      blinks   = '0;
      lamp_on  = 1'b0;
      group_on = 1'b0;
      lamp_t   = '0;
      group_t  = now;
    end
  endfunction

  function automatic slbs_pkg::slbs_out_t predict_pin(input slbs_pkg::slbs_in_t poll);
    slbs_pkg::slbs_out_t res;
    drove = 1'b0;
    if (settings.led_enable) begin
      if (poll.connected) begin
        level_q = slbs_pkg::PIN_LIT;
        drove   = 1'b1;
      end else if (poll.web_config) begin
        run_group(poll.now_ms, settings.web_on_ms, settings.web_off_ms,
                  slbs_pkg::WEB_BLINKS, settings.web_gap_ms);
      end else if (poll.link_mode == slbs_pkg::LINK_TCP) begin
        run_group(poll.now_ms, settings.net_on_ms, settings.net_off_ms,
                  slbs_pkg::TCP_BLINKS, settings.tcp_gap_ms);
      end else if (poll.link_mode == slbs_pkg::LINK_UDP) begin
        run_group(poll.now_ms, settings.net_on_ms, settings.net_off_ms,
                  slbs_pkg::UDP_BLINKS, settings.udp_gap_ms);
      end
    end
    res.pin_level  = level_q;
    res.pin_driven = drove;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    slbs_pkg::slbs_out_t want;
    if (!rst_n) begin
      settings = {1'b0, slbs_pkg::WEB_ON_RST, slbs_pkg::WEB_OFF_RST, slbs_pkg::WEB_GAP_RST,
                  slbs_pkg::NET_ON_RST, slbs_pkg::NET_OFF_RST, slbs_pkg::TCP_GAP_RST,
                  slbs_pkg::UDP_GAP_RST};
      group_on = 1'b0;
      lamp_on  = 1'b0;
      blinks   = '0;
      lamp_t   = '0;
      group_t  = '0;
      level_q  = slbs_pkg::PIN_DARK;
      drove    = 1'b0;
      expected_pins.delete();
    end else begin
      // compare first so a poll taken this edge cannot match a result of this edge
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          $error("result with no poll pending: pin_level %0b pin_driven %0b",
                 out_item.pin_level, out_item.pin_driven);
          fail_count++;
        end else begin
          want = expected_pins.pop_front();
          if (out_item.pin_level !== want.pin_level) begin
            $error("pin_level: expected %0b, got %0b", want.pin_level, out_item.pin_level);
            fail_count++;
          end
          if (out_item.pin_driven !== want.pin_driven) begin
            $error("pin_driven: expected %0b, got %0b", want.pin_driven,
                   out_item.pin_driven);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          slbs_pkg::REG_LED_ENABLE: settings.led_enable = cfg_data[0];
          slbs_pkg::REG_WEB_ON:     settings.web_on_ms  = cfg_data;
          slbs_pkg::REG_WEB_OFF:    settings.web_off_ms = cfg_data;
          slbs_pkg::REG_WEB_GAP:    settings.web_gap_ms = cfg_data;
          slbs_pkg::REG_NET_ON:     settings.net_on_ms  = cfg_data;
          slbs_pkg::REG_NET_OFF:    settings.net_off_ms = cfg_data;
          slbs_pkg::REG_TCP_GAP:    settings.tcp_gap_ms = cfg_data;
          slbs_pkg::REG_UDP_GAP:    settings.udp_gap_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_pins.push_back(predict_pin(in_item));
    end
    outstanding <= expected_pins.size();
  end

endmodule

@@ bench/testbench.sv @@
// Bench top for the status LED blink sequencer: stimulus, flow control and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous: the slowest legal run stays well inside this limit.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_POLLS = 140;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned HOLD_CYCLES = 80;

  // kinds of poll runs in the random part
  typedef enum int unsigned {RUN_WEB, RUN_TCP, RUN_UDP, RUN_LINKED, RUN_OTHER} poll_run_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  slbs_pkg::slbs_in_t             in_item   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  slbs_pkg::slbs_out_t            out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [slbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [slbs_pkg::MS_W-1:0]      cfg_data  = '0;

  int unsigned outstanding;
  int unsigned fail_count;

  // flow control knobs
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  logic        pressure_armed = 1'b0;
  logic        pressure_done  = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  // running millisecond timestamp shared by all random phases
  logic [slbs_pkg::TIME_W-1:0] poll_clock = '0;

  status_led_blink_sequencer_unit dut (.*);
  slbs_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off while the sender keeps going,
  // so that both pipeline stages fill and in_stall has to rise.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (pressure_armed && !pressure_done) begin
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[status_led_blink_sequencer_unit] ERROR");
    $finish;
  end

  // One poll transaction. Optional idle cycles first; the payload then holds
  // until the block takes it. valid is left high for a back-to-back follower.
  task automatic send_poll(input logic [slbs_pkg::TIME_W-1:0] now, input logic conn, web,
                           input logic [1:0] mode);
    slbs_pkg::slbs_in_t poll;
    poll.now_ms     = now;
    poll.connected  = conn;
    poll.web_config = web;
    poll.link_mode  = mode;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= poll;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and let every outstanding result come back, then idle on to let
  // the last poll clear both pipeline stages.
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [slbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slbs_pkg::MS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrite every register while the block is idle. An unmapped index goes first;
  // the block must ignore it. Upper bits of the enable write are junk on purpose.
  task automatic program_regs(input slbs_pkg::slbs_cfg_t s);
    wait_idle();
    cfg_write(slbs_pkg::CFG_IDX_W'($urandom_range(8, 255)), slbs_pkg::MS_W'($urandom()));
    cfg_write(slbs_pkg::REG_LED_ENABLE, {15'($urandom()), s.led_enable});
    cfg_write(slbs_pkg::REG_WEB_ON,  s.web_on_ms);
    cfg_write(slbs_pkg::REG_WEB_OFF, s.web_off_ms);
    cfg_write(slbs_pkg::REG_WEB_GAP, s.web_gap_ms);
    cfg_write(slbs_pkg::REG_NET_ON,  s.net_on_ms);
    cfg_write(slbs_pkg::REG_NET_OFF, s.net_off_ms);
    cfg_write(slbs_pkg::REG_TCP_GAP, s.tcp_gap_ms);
    cfg_write(slbs_pkg::REG_UDP_GAP, s.udp_gap_ms);
    cfg_valid <= 1'b0;
  endtask

  // Random polls: mostly runs of one mode with time moving forward in steps
  // comparable to the programmed timings, so blink groups actually play out.
  // A few polls jump anywhere in time, step backward, or carry random fields.
  task automatic random_polls(input int unsigned count, input int unsigned tick_max);
    poll_run_t   kind;
    int unsigned run_left;
    int unsigned roll;
    logic        conn;
    logic        web;
    logic [1:0]  mode;
    run_left = 0;
    kind     = RUN_TCP;
    for (int unsigned i = 0; i < count; i++) begin
      if (run_left == 0) begin
        roll = $urandom_range(99);
        if (roll < 30)      kind = RUN_WEB;
        else if (roll < 60) kind = RUN_TCP;
        else if (roll < 88) kind = RUN_UDP;
        else if (roll < 94) kind = RUN_LINKED;
        else                kind = RUN_OTHER;
        run_left = $urandom_range(5, 60);
      end
      run_left--;

      roll = $urandom_range(99);
      if (roll < 3)      poll_clock = $urandom();
      else if (roll < 6) poll_clock = poll_clock - $urandom_range(tick_max);
      else               poll_clock = poll_clock + $urandom_range(tick_max);

      conn = 1'b0;
      web  = 1'b0;
      mode = 2'($urandom_range(3));
      case (kind)
        RUN_WEB:    web  = 1'b1;   // link mode is don't-care under web config
        RUN_TCP:    mode = slbs_pkg::LINK_TCP;
        RUN_UDP:    mode = slbs_pkg::LINK_UDP;
        RUN_LINKED: begin
          conn = 1'b1;
          web  = 1'($urandom_range(1));
        end
        default:    mode = 2'($urandom_range(2, 3));
      endcase
      if ($urandom_range(99) < 5) begin
        conn = 1'($urandom_range(1));
        web  = 1'($urandom_range(1));
        mode = 2'($urandom_range(3));
      end
      send_poll(poll_clock, conn, web, mode);
    end
  endtask

  initial begin : stimulus
    slbs_pkg::slbs_cfg_t setup;
    int unsigned         tick_max;
    int unsigned         lo;
    int unsigned         hi;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Out of reset the LED is disabled: polls change nothing, pin reads dark.
    send_poll(32'd0,    1'b0, 1'b0, slbs_pkg::LINK_TCP);
    send_poll(32'd5000, 1'b1, 1'b1, slbs_pkg::LINK_UDP);

    // Enable with the default timings.
    setup = {1'b1, slbs_pkg::WEB_ON_RST, slbs_pkg::WEB_OFF_RST, slbs_pkg::WEB_GAP_RST,
             slbs_pkg::NET_ON_RST, slbs_pkg::NET_OFF_RST, slbs_pkg::TCP_GAP_RST,
             slbs_pkg::UDP_GAP_RST};
    program_regs(setup);

    send_poll(32'd0,    1'b1, 1'b0, slbs_pkg::LINK_TCP);   // connected: steady lit
    send_poll(32'd0,    1'b0, 1'b0, slbs_pkg::LINK_TCP);   // TCP gap still running: dark
    send_poll(32'd2200, 1'b0, 1'b0, slbs_pkg::LINK_TCP);   // gap met exactly: lit
    send_poll(32'd2380, 1'b0, 1'b0, slbs_pkg::LINK_TCP);   // on time met: group ends
    send_poll(32'd2400, 1'b0, 1'b0, 2'd2);       // unknown link modes leave state alone
    send_poll(32'd2400, 1'b0, 1'b0, 2'd3);
    // UDP: two blinks after its gap
    send_poll(32'd4280, 1'b0, 1'b0, slbs_pkg::LINK_UDP);
    send_poll(32'd4460, 1'b0, 1'b0, slbs_pkg::LINK_UDP);
    send_poll(32'd4580, 1'b0, 1'b0, slbs_pkg::LINK_UDP);
    send_poll(32'd4760, 1'b0, 1'b0, slbs_pkg::LINK_UDP);
    // Web config: five blinks at 400 ms, link mode ignored
    for (int unsigned k = 0; k < 10; k++)
      send_poll(32'd5160 + 32'd400 * k, 1'b0, 1'b1, 2'(k));
    // Timestamp wrap: differences are taken modulo 2^32
    send_poll(32'hFFFF_FF00, 1'b0, 1'b0, slbs_pkg::LINK_TCP);
    send_poll(32'h0000_0800, 1'b0, 1'b0, slbs_pkg::LINK_TCP);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3);

    // ---- random part ----
    // Each phase picks its timing set and a flow-control pattern.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 56; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 56; end
        default: begin send_idle_pct = 7; stall_pct <= 7; end
      endcase

      lo = 0;
      hi = 0;
      case (ph)
        0: tick_max = 800;                                  // defaults
        1: tick_max = 3;                                    // all timings zero
        2: begin lo = 16'hFFFF; hi = 16'hFFFF; tick_max = 20000; end
        3: begin hi = 20;    tick_max = 12;    end
        4: begin hi = 65535; tick_max = 20000; poll_clock = 32'hFFFF_0000; end
        5: begin hi = 100;   tick_max = 50;    end          // LED disabled
        6: begin hi = 300;   tick_max = 150;   end
        7: tick_max = 20000;                                // each timing zero or max
        default: begin lo = 1; hi = 40; tick_max = 25; end
      endcase

      setup = {1'b1, slbs_pkg::WEB_ON_RST, slbs_pkg::WEB_OFF_RST, slbs_pkg::WEB_GAP_RST,
               slbs_pkg::NET_ON_RST, slbs_pkg::NET_OFF_RST, slbs_pkg::TCP_GAP_RST,
               slbs_pkg::UDP_GAP_RST};
      if (ph != 0) begin
        for (int unsigned f = 0; f < 7; f++) begin
          if (ph == 7) begin
            setup[f*slbs_pkg::MS_W +: slbs_pkg::MS_W] = $urandom_range(1) ? 16'hFFFF
                                                                           : 16'h0000;
          end else begin
            setup[f*slbs_pkg::MS_W +: slbs_pkg::MS_W] =
              slbs_pkg::MS_W'($urandom_range(hi, lo));
          end
        end
      end
      setup.led_enable = (ph != 5);
      program_regs(setup);

      // long receiver hold-off once, in a phase where the sender never idles
      if (ph == 0) pressure_armed <= 1'b1;
      random_polls(PHASE_POLLS, tick_max);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("[status_led_blink_sequencer_unit] OK");
    end else begin
      $display("[status_led_blink_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule
